[hw/rtl/spfa_pkg.sv]
// Package: shared constants, types and controller/datapath command structs.
`default_nettype none
package spfa_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 1024;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int LinkW = $clog2(MaxEdges + 1);
  localparam int CntW = $clog2(MaxNodes + 1);
  localparam int WtW = 16;
  localparam int DistW = 32;
  localparam logic [DistW-1:0] DistInf = '1;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgStartNode = 1'b1;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRun = 1'b1;

  typedef struct packed {
    logic [NodeW-1:0] dest;
    logic [LinkW-1:0] link;
    logic [WtW-1:0]   wt;
  } edge_t;

  typedef struct packed {
    logic load_head_rd;  // read head of src, capture load fields
    logic load_wr;       // write edge and head
    logic init_node;     // set distance of node idx to infinity, clear its mark
    logic seed;          // seed start node
    logic pop;           // pop fifo into u
    logic edge_rd;       // read dist/head of u, clear its mark
    logic relax_rd;      // read edge at link
    logic dest_rd;       // read dist of dest
    logic relax_wr;      // conditional update
    logic out_rd;        // read dist of idx for output
    logic clear_head;    // clear head idx
    logic clear_graph;   // reset count and flag
  } cmd_t;

  typedef struct packed {
    logic fifo_empty;
    logic link_zero;
    logic u_inf;
  } sts_t;
endpackage
`default_nettype wire

[hw/rtl/spfa_if.sv]
// Interface: valid/ready channel with a generic payload.
`default_nettype none
interface spfa_if #(parameter type T = logic) (input wire logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/spfa_datapath.sv]
// Datapath: edge store, heads, distances, marks and node FIFO.
`default_nettype none
module spfa_datapath import spfa_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  input  wire logic [NodeW-1:0] idx_i,
  input  wire logic [NodeW-1:0] src_i,
  input  wire logic [NodeW-1:0] dst_i,
  input  wire logic [WtW-1:0]  wt_i,
  input  wire logic [CntW-1:0] n_i,
  input  wire logic [NodeW-1:0] start_i,
  output sts_t                 sts_o,
  output logic [DistW-1:0]     dist_o,
  output logic                 dropped_o
);
  edge_t            edge_mem [MaxEdges];
  logic [LinkW-1:0] head_mem [MaxNodes];
  logic [DistW-1:0] dist_mem [MaxNodes];
  logic [MaxNodes-1:0] mark_q;
  logic [NodeW-1:0] fifo_mem [MaxNodes];
  logic [NodeW-1:0] rd_q, wr_q;
  logic [CntW-1:0]  len_q;
  logic [LinkW-1:0] count_q, head_q, link_q;
  logic             ovf_q;
  edge_t            edge_q;
  logic [DistW-1:0] du_q, dv_q;
  logic [NodeW-1:0] u_q;
  logic [NodeW-1:0] ld_src_q, ld_dst_q;
  logic [WtW-1:0]   ld_wt_q;
  logic [DistW-1:0] nd;
  logic             push;

  assign nd = du_q + DistW'(edge_q.wt);
  assign push = cmd_i.relax_wr && ({1'b0, edge_q.dest} < n_i) && (nd < dv_q)
                && !mark_q[edge_q.dest];

  // Memories without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_head_rd) begin
      head_q   <= head_mem[src_i];
      ld_src_q <= src_i;
      ld_dst_q <= dst_i;
      ld_wt_q  <= wt_i;
    end
    if (cmd_i.load_wr && count_q != LinkW'(MaxEdges)) begin
      edge_mem[count_q[EdgeW-1:0]] <= '{dest: ld_dst_q, link: head_q, wt: ld_wt_q};
      head_mem[ld_src_q] <= count_q + 1'b1;
    end
    if (cmd_i.clear_head) head_mem[idx_i] <= '0;
    if (cmd_i.init_node) dist_mem[idx_i] <= DistInf;
    if (cmd_i.seed) begin
      dist_mem[start_i] <= '0;
      fifo_mem[wr_q] <= start_i;
    end
    if (cmd_i.pop) u_q <= fifo_mem[rd_q];
    if (cmd_i.edge_rd) begin
      du_q   <= dist_mem[u_q];
      link_q <= head_mem[u_q];
    end
    if (cmd_i.relax_rd) begin
      edge_q <= edge_mem[link_q[EdgeW-1:0] - 1'b1];
      link_q <= edge_mem[link_q[EdgeW-1:0] - 1'b1].link;
    end
    if (cmd_i.dest_rd) dv_q <= dist_mem[edge_q.dest];
    if (cmd_i.relax_wr && ({1'b0, edge_q.dest} < n_i) && (nd < dv_q))
      dist_mem[edge_q.dest] <= nd;
    if (push) fifo_mem[wr_q] <= edge_q.dest;
    if (cmd_i.out_rd) dist_o <= dist_mem[idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0; rd_q <= '0; wr_q <= '0; len_q <= '0;
      count_q <= '0; ovf_q <= 1'b0;
    end else begin
      if (cmd_i.load_wr) begin
        if (count_q == LinkW'(MaxEdges)) ovf_q <= 1'b1;
        else count_q <= count_q + 1'b1;
      end
      if (cmd_i.init_node) mark_q[idx_i] <= 1'b0;
      if (cmd_i.seed) begin
        mark_q[start_i] <= 1'b1;
        wr_q <= wr_q + 1'b1;
        len_q <= len_q + 1'b1;
      end
      if (cmd_i.pop) rd_q <= rd_q + 1'b1;
      if (cmd_i.edge_rd) mark_q[u_q] <= 1'b0;
      if (push) begin
        mark_q[edge_q.dest] <= 1'b1;
        wr_q <= wr_q + 1'b1;
      end
      if (cmd_i.pop && !push) len_q <= len_q - 1'b1;
      else if (push && !cmd_i.pop) len_q <= len_q + 1'b1;
      if (cmd_i.clear_graph) begin
        count_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  assign sts_o.fifo_empty = (len_q == '0);
  assign sts_o.link_zero  = (link_q == '0);
  assign sts_o.u_inf      = (du_q == DistInf);
  assign dropped_o        = ovf_q;
endmodule
`default_nettype wire

[hw/rtl/spfa_ctrl.sv]
// Controller: sequences loads, search, output and clearing.
`default_nettype none
module spfa_ctrl import spfa_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_mode_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 out_last_o,
  input  wire logic [CntW-1:0] n_i,
  input  wire logic [NodeW-1:0] start_i,
  input  wire sts_t            sts_i,
  output cmd_t                 cmd_o,
  output logic [NodeW-1:0]     idx_o,
  output logic [NodeW-1:0]     out_node_o
);
  typedef enum logic [3:0] {
    StIdle, StLoad, StInit, StSeed, StPop, StFetch, StCheck, StEdge, StDist, StRelax,
    StOutRd, StOutShow, StClear
  } state_e;
  state_e state_q;
  logic [NodeW-1:0] idx_q;
  logic             last;

  assign in_ready_o = (state_q == StIdle);
  assign idx_o = idx_q;
  assign last = ({1'b0, idx_q} == n_i - 1'b1);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:  cmd_o.load_head_rd = in_valid_i && in_mode_i == ModeLoad;
      StLoad:  cmd_o.load_wr = 1'b1;
      StInit:  cmd_o.init_node = 1'b1;
      StSeed:  cmd_o.seed = ({1'b0, start_i} < n_i);
      StPop:   cmd_o.pop = !sts_i.fifo_empty;
      StFetch: cmd_o.edge_rd = 1'b1;
      StEdge:  cmd_o.relax_rd = 1'b1;
      StDist:  cmd_o.dest_rd = 1'b1;
      StRelax: cmd_o.relax_wr = 1'b1;
      StOutRd: cmd_o.out_rd = 1'b1;
      StClear: begin
        cmd_o.clear_head = 1'b1;
        cmd_o.clear_graph = &idx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; idx_q <= '0;
      out_valid_o <= 1'b0; out_last_o <= 1'b0; out_node_o <= '0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) begin
          idx_q <= '0;
          state_q <= (in_mode_i == ModeRun) ? StInit : StLoad;
        end
        StLoad: state_q <= StIdle;
        StInit: begin
          idx_q <= idx_q + 1'b1;
          if (&idx_q) state_q <= StSeed;
        end
        StSeed: state_q <= StPop;
        StPop: state_q <= sts_i.fifo_empty ? StOutRd : StFetch;
        StFetch: state_q <= StCheck;
        StCheck: state_q <= (sts_i.u_inf || sts_i.link_zero) ? StPop : StEdge;
        StEdge: state_q <= StDist;
        StDist: state_q <= StRelax;
        StRelax: state_q <= sts_i.link_zero ? StPop : StEdge;
        StOutRd: begin
          out_valid_o <= 1'b1;
          out_node_o <= idx_q;
          out_last_o <= last || n_i == '0;
          state_q <= StOutShow;
        end
        StOutShow: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          if (out_last_o) begin
            idx_q <= '0; state_q <= StClear;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= StOutRd;
          end
        end
        StClear: begin
          idx_q <= idx_q + 1'b1;
          if (&idx_q) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/spfa_shortest_path.sv]
// Top level: queue-driven shortest-path engine with edge load and run items.
//  channel  dir  payload
//  in_if    in   mode, src_node, dst_node, weight
//  out_if   out  node, distance, reachable, edges_dropped, last
//  cfg      in   node_count (0), start_node (1)
// A load item does a head read, then an edge and head write.
// A run item initialises every node and seeds the start node, then per popped node
// fetches and checks it and per edge scanned reads the edge, the dest distance and
// relaxes; then a final empty check, the results (held by stalls), clearing the heads.
// Reset clears control state and starts a pass that zeroes every head
// before the first item is taken; other stores hold garbage until written.
// A stalled result holds the controller; no item is taken until all are done.
`default_nettype none
module spfa_shortest_path import spfa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spfa_if.sink             in_if,
  spfa_if.source           out_if,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i
);
  logic [6:0]       node_count_q;
  logic [NodeW-1:0] start_q;
  logic [CntW-1:0]  n;
  cmd_t             cmd;
  sts_t             sts;
  logic [NodeW-1:0] idx, out_node;
  logic [DistW-1:0] node_dist;
  logic             dropped, last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd64; start_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgNodeCount) node_count_q <= cfg_data_i;
      else start_q <= cfg_data_i[NodeW-1:0];
    end
  end

  // Clamp node count to 1..MaxNodes.
  assign n = (node_count_q == '0) ? CntW'(1) :
             (node_count_q > 7'(MaxNodes)) ? CntW'(MaxNodes) : CntW'(node_count_q);

  spfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_mode_i(in_if.data.mode), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_last_o(last),
    .n_i(n), .start_i(start_q), .sts_i(sts), .cmd_o(cmd), .idx_o(idx),
    .out_node_o(out_node)
  );

  spfa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx),
    .src_i(in_if.data.src_node), .dst_i(in_if.data.dst_node), .wt_i(in_if.data.weight),
    .n_i(n), .start_i(start_q), .sts_o(sts), .dist_o(node_dist), .dropped_o(dropped)
  );

  assign out_if.data.node = out_node;
  assign out_if.data.distance = node_dist;
  assign out_if.data.reachable = (node_dist != DistInf);
  assign out_if.data.edges_dropped = dropped;
  assign out_if.data.last = last;
endmodule
`default_nettype wire

[hw/rtl/spfa_checker.sv]
// Checker: port-level properties of the shortest-path block, with bind.
`default_nettype none
module spfa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while results pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("back-to-back accept");
endmodule
bind spfa_shortest_path spfa_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready)
);
`default_nettype wire
